### hdl/dqfc_pkg.sv
// Shared constants and the result struct type for the binary64/binary128 converter.
// Used by the converter datapath and the top level.
`timescale 1ns / 1ps
package dqfc_pkg;
    localparam int unsigned QUAD_BIAS = 16383;
    localparam int unsigned DBL_BIAS  = 1023;
    localparam logic [14:0] QUAD_EXP_MAX = 15'h7fff;
    localparam logic [10:0] DBL_EXP_MAX  = 11'h7ff;
    localparam logic MODE_WIDEN  = 1'b0;
    localparam logic MODE_NARROW = 1'b1;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        logic        nan_error;
    } dqfc_result_t;
endpackage

### hdl/dqfc_convert.sv
// Combinational conversion datapath: widen binary64 to quad, or narrow quad to binary64.
// Depends on dqfc_pkg.
`timescale 1ns / 1ps
module dqfc_convert
    import dqfc_pkg::*;
(
    input  logic         mode,
    input  logic [63:0]  operand_low,
    input  logic [63:0]  operand_high,
    output dqfc_result_t result
);
    // Widening path
    logic        w_sign;
    logic [10:0] w_exp;
    logic [51:0] w_frac;
    logic [5:0]  w_lead;
    logic [51:0] w_norm;
    logic [14:0] w_qexp;
    logic [63:0] w_hi, w_lo;

    // Leading one position for subnormal normalization (priority encode)
    always_comb
    begin
        w_lead = 6'd0;
        for (int i = 0; i < 52; i++)
        begin
            if (w_frac[i])
            begin
                w_lead = 6'(i);
            end
        end
    end

    always_comb
    begin
        w_sign = operand_low[63];
        w_exp  = operand_low[62:52];
        w_frac = operand_low[51:0];
        w_norm = w_frac << (6'd52 - w_lead);
        w_hi   = 64'd0;
        w_lo   = 64'd0;
        w_qexp = 15'd0;
        if (w_exp == DBL_EXP_MAX)
        begin
            if (w_frac != 52'd0)
                w_hi = {1'b0, QUAD_EXP_MAX, 1'b1, 47'd0};
            else
                w_hi = {w_sign, QUAD_EXP_MAX, 48'd0};
        end
        else if (w_exp == 11'd0 && w_frac == 52'd0)
        begin
            w_hi = 64'd0;
        end
        else if (w_exp == 11'd0)
        begin
            // p - 1074 + 16383
            w_qexp = 15'(15'd15309 + {9'd0, w_lead});
            w_hi   = {w_sign, w_qexp, w_norm[51:4]};
            w_lo   = {w_norm[3:0], 60'd0};
        end
        else
        begin
            w_qexp = 15'({4'd0, w_exp} + 15'(QUAD_BIAS - DBL_BIAS));
            w_hi   = {w_sign, w_qexp, w_frac[51:4]};
            w_lo   = {w_frac[3:0], 60'd0};
        end
    end

    // Narrowing path
    logic        n_sign;
    logic [14:0] n_qe;
    logic [47:0] n_fh;
    logic        n_nan;
    logic [63:0] n_res;
    logic [51:0] n_top;
    logic [59:0] n_rem;
    logic [62:0] n_r;
    logic [6:0]  n_k;      // right shift of 64-bit t, 12..64
    logic [63:0] n_t;
    logic [63:0] n_q;
    logic [127:0] n_ext;   // t followed by 64 zeros, shifted
    logic        n_guard, n_sticky;
    logic [10:0] n_de;

    always_comb
    begin
        n_sign = operand_high[63];
        n_qe   = operand_high[62:48];
        n_fh   = operand_high[47:0];
        n_nan  = 1'b0;
        n_res  = 64'd0;
        n_top  = {n_fh, operand_low[63:60]};
        n_rem  = operand_low[59:0];
        n_de   = 11'(n_qe - 15'(QUAD_BIAS - DBL_BIAS));
        n_r    = {n_de, n_top};
        n_t    = {1'b1, n_fh, operand_low[63:49]};
        // sh = 15421 - qe ; k = sh - 49 = 15372 - qe
        n_k    = 7'(15'd15372 - n_qe);
        n_ext  = {n_t, 64'd0} >> n_k;
        n_q    = n_ext[127:64];
        n_guard  = n_ext[63];
        n_sticky = (n_ext[62:0] != 63'd0) || (operand_low[48:0] != 49'd0);
        if (n_qe == QUAD_EXP_MAX)
        begin
            if (n_fh != 48'd0 || operand_low != 64'd0)
                n_nan = 1'b1;
            else
                n_res = {n_sign, DBL_EXP_MAX, 52'd0};
        end
        else if (n_qe >= 15'd17407)
        begin
            n_res = {n_sign, DBL_EXP_MAX, 52'd0};
        end
        else if (n_qe >= 15'd15361)
        begin
            if (n_rem > {1'b1, 59'd0} || (n_rem == {1'b1, 59'd0} && n_top[0]))
                n_r = 63'(n_r + 63'd1);
            n_res = {n_sign, n_r};
        end
        else if (n_qe <= 15'd15307)
        begin
            // zero, quad subnormal, or far below half the smallest subnormal
            n_res = {n_sign, 63'd0};
        end
        else
        begin
            if (n_guard && (n_sticky || n_q[0]))
                n_q = 64'(n_q + 64'd1);
            n_res = {n_sign, n_q[62:0]};
        end
    end

    always_comb
    begin
        if (mode == MODE_WIDEN)
        begin
            result.low       = w_lo;
            result.high      = w_hi;
            result.nan_error = 1'b0;
        end
        else
        begin
            result.low       = n_res;
            result.high      = 64'd0;
            result.nan_error = n_nan;
        end
    end
endmodule

### hdl/double_quad_float_converter_core.sv
// Top level of the binary64/binary128 converter: input register, datapath, output register.
// Depends on dqfc_pkg and dqfc_convert.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, operand_low, operand_high.
//   Mode 0 widens binary64 to quad; mode 1 narrows quad to binary64 with one
//   round to nearest even, flagging quad NaN on nan_error.
//   Output channel (out_valid/out_ready) carries result_low, result_high,
//   nan_error.
//   Path: an accepted input is held in the input register, converted by the
//   combinational datapath and captured in the result register that drives
//   the outputs. Throughput: one transfer per cycle while out_ready holds,
//   set by the single-pass conversion logic between the two registers.
//   Each stage is ready whenever it is empty or the stage after it empties in
//   the same cycle, so a stalled receiver holds results in place and fills
//   the pipeline; once both stages are full in_ready drops.
//   Reset clears both stage valid flags; no transfer is in flight afterwards.
`timescale 1ns / 1ps
module double_quad_float_converter_core
    import dqfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [63:0] operand_low,
    input  logic [63:0] operand_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic        nan_error
);
    logic        s1_valid_reg;
    logic        s1_mode_reg;
    logic [63:0] s1_low_reg, s1_high_reg;
    logic        s2_valid_reg;
    dqfc_result_t s2_res_reg, s2_res_next;
    logic        s2_ready, s1_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Input operand register
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_mode_reg <= mode;
            s1_low_reg  <= operand_low;
            s1_high_reg <= operand_high;
        end
    end

    dqfc_convert u_convert (
        .mode         (s1_mode_reg),
        .operand_low  (s1_low_reg),
        .operand_high (s1_high_reg),
        .result       (s2_res_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
            s2_res_reg <= s2_res_next;
    end

    assign out_valid   = s2_valid_reg;
    assign result_low  = s2_res_reg.low;
    assign result_high = s2_res_reg.high;
    assign nan_error   = s2_res_reg.nan_error;

    // Stalled result must hold (result_low and nan_error are checked)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_low) && $stable(nan_error))
        else $error("result changed under stall");
    // A NaN-flagged result must have both words zero
    a_narrow_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && nan_error |-> result_high == 64'd0 && result_low == 64'd0)
        else $error("nan result not zero");
    // Full pipeline with a stalled receiver must block input
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && !out_ready |-> !in_ready)
        else $error("accepted into full pipeline");
endmodule
